// ----- design/cleb_pkg.sv -----
// Shared types and constants for the console line edit buffer.
package cleb_pkg;

  // Request codes on the input channel.
  localparam logic REQ_RX   = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Result kinds on the output channel.
  localparam logic [1:0] KIND_ECHO      = 2'd0;
  localparam logic [1:0] KIND_LINE      = 2'd1;
  localparam logic [1:0] KIND_NOT_READY = 2'd2;
  localparam logic [1:0] KIND_REFUSED   = 2'd3;

  // Character codes.
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_DEL = 8'h7F;

  // Pending output job, one per accepted item that produces results.
  typedef enum logic [2:0] {
    JOB_CRLF   = 3'd0,
    JOB_ERASE  = 3'd1,
    JOB_ECHO   = 3'd2,
    JOB_NOTRDY = 3'd3,
    JOB_REFUSE = 3'd4,
    JOB_LINE   = 3'd5
  } job_t;

endpackage

// ----- design/cleb_in_if.sv -----
// Input channel of the console line edit buffer: request type and received byte.
interface cleb_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

// ----- design/cleb_out_if.sv -----
// Output channel of the console line edit buffer: echo, line and status results.
interface cleb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic       run_last;
  logic       line_end;

  modport source (output valid, output kind, output data_byte, output run_last,
                  output line_end, input ready);
  modport sink   (input valid, input kind, input data_byte, input run_last,
                  input line_end, output ready);
endinterface

// ----- design/console_line_edit_buffer.sv -----
// Top level of the console line edit buffer: line editing, echo and line delivery.
//
// The block collects received console bytes into a line store and echoes them.
// Backspace and DEL erase the last held byte and echo backspace, space,
// backspace; CR or LF stores a newline, echoes CR LF and completes the line.
// A plain byte is stored only while fewer than LINE_DEPTH-2 bytes are held and
// is dropped without echo otherwise. Once a line is complete, each read request
// returns the next stored byte, the closing newline flagged by line_end, and
// after that byte the block returns to collecting. A read while collecting
// answers "no line ready"; a received byte while delivering is refused and must
// be resent. Every result leaves as one beat on the output channel, so an item
// holds the output until all of its results (one to three) are taken, and the
// next item is accepted in the same cycle as the last beat of the previous one
// is taken. An item with no result leaves the output free. A delivered line byte comes
// from the line store RAM, whose registered read makes it appear the cycle after
// the read request is accepted. The line store needs no clearing after reset:
// only entries written for the current line are ever read.
module console_line_edit_buffer
  import cleb_pkg::*;
#(
  parameter int LINE_DEPTH = 512
) (
  input logic       clk,
  input logic       rst,
  cleb_in_if.sink   in_ch,
  cleb_out_if.source out_ch
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int CW = $clog2(LINE_DEPTH + 1);
  localparam logic [CW-1:0] FILL_LIMIT = CW'(LINE_DEPTH - 2);
  localparam logic [CW-1:0] FILL_CAP   = CW'(LINE_DEPTH);

  // Editing state.
  logic [CW-1:0] fill_count, fill_count_next;
  logic [AW-1:0] read_index, read_index_next;
  logic          delivering, delivering_next;

  // Result register: the job being emitted and its beat position.
  logic       job_valid;
  job_t       job;
  logic [7:0] job_byte;
  logic       job_end;
  logic [1:0] beat;

  logic       has_job;
  job_t       job_next;
  logic       end_next;

  logic       ram_we;
  logic [7:0] ram_wdata;
  logic       ram_re;
  logic [7:0] ram_rdata;

  logic       take, done, accept;
  logic       is_newline, is_erase;
  logic [CW-1:0] read_plus;

  // The input side is free once the current job's last beat leaves.
  assign take         = out_ch.valid && out_ch.ready;
  assign done         = take && out_ch.run_last;
  assign in_ch.ready  = !job_valid || done;
  assign accept       = in_ch.valid && in_ch.ready;

  assign is_newline = (in_ch.rx_byte == CH_CR) || (in_ch.rx_byte == CH_LF);
  assign is_erase   = (in_ch.rx_byte == CH_BS) || (in_ch.rx_byte == CH_DEL);
  assign read_plus  = CW'(read_index) + CW'(1);

  // Decode of one item against the current state.
  always_comb begin
    fill_count_next = fill_count;
    read_index_next = read_index;
    delivering_next = delivering;
    has_job         = 1'b0;
    job_next        = JOB_ECHO;
    end_next        = 1'b0;
    ram_we          = 1'b0;
    ram_wdata       = in_ch.rx_byte;
    ram_re          = 1'b0;
    if (delivering) begin
      has_job = 1'b1;
      if (in_ch.req_type == REQ_RX) begin
        job_next = JOB_REFUSE;
      end else begin
        job_next = JOB_LINE;
        ram_re   = accept;
        end_next = (read_plus >= fill_count);
        if (read_plus >= fill_count) begin
          fill_count_next = '0;
          read_index_next = '0;
          delivering_next = 1'b0;
        end else begin
          read_index_next = read_plus[AW-1:0];
        end
      end
    end else if (in_ch.req_type == REQ_READ) begin
      has_job  = 1'b1;
      job_next = JOB_NOTRDY;
    end else if (is_newline) begin
      has_job         = 1'b1;
      job_next        = JOB_CRLF;
      ram_wdata       = CH_LF;
      read_index_next = '0;
      delivering_next = 1'b1;
      if (fill_count < FILL_CAP) begin
        ram_we          = accept;
        fill_count_next = fill_count + CW'(1);
      end
    end else if (is_erase) begin
      if (fill_count != '0) begin
        has_job         = 1'b1;
        job_next        = JOB_ERASE;
        fill_count_next = fill_count - CW'(1);
      end
    end else if (fill_count < FILL_LIMIT) begin
      has_job         = 1'b1;
      job_next        = JOB_ECHO;
      ram_we          = accept;
      fill_count_next = fill_count + CW'(1);
    end
  end

  cleb_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_count[AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (read_index),
    .rdata (ram_rdata)
  );

  // State and result register update.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      read_index <= '0;
      delivering <= 1'b0;
      job_valid  <= 1'b0;
      beat       <= '0;
    end else begin
      if (accept) begin
        fill_count <= fill_count_next;
        read_index <= read_index_next;
        delivering <= delivering_next;
        job_valid  <= has_job;
        beat       <= '0;
      end else if (done) begin
        job_valid <= 1'b0;
        beat      <= '0;
      end else if (take) begin
        beat <= beat + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job      <= job_next;
      job_byte <= in_ch.rx_byte;
      job_end  <= end_next;
    end
  end

  // Beat formatting from the result register.
  always_comb begin
    out_ch.valid     = job_valid;
    out_ch.kind      = KIND_ECHO;
    out_ch.data_byte = '0;
    out_ch.run_last  = 1'b1;
    out_ch.line_end  = 1'b0;
    case (job)
      JOB_CRLF: begin
        out_ch.data_byte = (beat == 2'd0) ? CH_CR : CH_LF;
        out_ch.run_last  = (beat != 2'd0);
      end
      JOB_ERASE: begin
        out_ch.data_byte = (beat == 2'd1) ? CH_SP : CH_BS;
        out_ch.run_last  = (beat == 2'd2);
      end
      JOB_ECHO: begin
        out_ch.data_byte = job_byte;
      end
      JOB_NOTRDY: begin
        out_ch.kind = KIND_NOT_READY;
      end
      JOB_REFUSE: begin
        out_ch.kind = KIND_REFUSED;
      end
      JOB_LINE: begin
        out_ch.kind      = KIND_LINE;
        out_ch.data_byte = ram_rdata;
        out_ch.line_end  = job_end;
      end
      default: begin
        out_ch.kind = KIND_ECHO;
      end
    endcase
  end

  // A completed line always holds at least its newline, and the read pointer
  // stays inside it.
  a_deliver_nonempty: assert property (@(posedge clk) disable iff (rst)
    delivering |-> (fill_count != '0) && (CW'(read_index) < fill_count))
    else $error("delivering with read pointer outside the held line");

  // The store never overflows: plain bytes stop two short of the depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count < FILL_CAP)
    else $error("line store fill count reached the depth");

  // A line end beat returns the block to collecting with an empty store.
  a_line_end_clears: assert property (@(posedge clk) disable iff (rst)
    (job_valid && job == JOB_LINE && job_end) |->
      (!delivering && fill_count == '0))
    else $error("line end delivered while line still held");

  // An item is never accepted while a beat is left over that is not its last.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (job_valid && !(take && out_ch.run_last)) |-> !accept)
    else $error("item accepted while results still pending");

endmodule

// ----- design/cleb_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module cleb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the console line edit buffer: editing, echo and line delivery.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cleb_pkg::*;

  // The block is built at its usual depth.
  localparam int LINE_DEPTH     = 512;
  localparam int RANDOM_ITEMS   = 260;
  // Cycles in a row with no beat on either channel before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 2000;
  // Quiet cycles allowed after the last expected beat, to catch stray output.
  localparam int TAIL_CYCLES    = 16;

  // Scoreboard: it keeps its own copy of the line editor's state, works out
  // the beats that every accepted request should cause, and checks the beats
  // that leave the block against them in order.
  class line_echo_scoreboard #(int DEPTH = 512);
    typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic       run_last;
      logic       line_end;
    } line_beat_t;

    line_beat_t  expected_beats[$];
    logic [7:0]  line_mem[DEPTH];
    int unsigned held;
    int unsigned next_rd;
    bit          delivering;
    int          errors;
    int          beat_no;

    function new();
      held       = 0;
      next_rd    = 0;
      delivering = 1'b0;
      errors     = 0;
      beat_no    = 0;
    endfunction

    function void push_beat(input logic [1:0] kind, input logic [7:0] data,
                            input logic last, input logic le);
      line_beat_t b;
      b.kind      = kind;
      b.data_byte = data;
      b.run_last  = last;
      b.line_end  = le;
      expected_beats.push_back(b);
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    // Notes one accepted request and returns how many beats it should cause.
    function int absorb_item(input logic req, input logic [7:0] rx);
      logic [7:0] got;
      logic       at_end;
      if (delivering) begin
        if (req == REQ_RX) begin
          push_beat(KIND_REFUSED, 8'h00, 1'b1, 1'b0);
          return 1;
        end
        got    = line_mem[next_rd];
        at_end = (next_rd + 1 >= held);
        next_rd++;
        if (next_rd >= held) begin
          held       = 0;
          next_rd    = 0;
          delivering = 1'b0;
        end
        push_beat(KIND_LINE, got, 1'b1, at_end);
        return 1;
      end
      if (req == REQ_READ) begin
        push_beat(KIND_NOT_READY, 8'h00, 1'b1, 1'b0);
        return 1;
      end
      if (rx == CH_CR || rx == CH_LF) begin
        if (held < DEPTH) begin
          line_mem[held] = CH_LF;
          held++;
        end
        next_rd    = 0;
        delivering = 1'b1;
        push_beat(KIND_ECHO, CH_CR, 1'b0, 1'b0);
        push_beat(KIND_ECHO, CH_LF, 1'b1, 1'b0);
        return 2;
      end
      if (rx == CH_BS || rx == CH_DEL) begin
        if (held == 0) return 0;
        held--;
        push_beat(KIND_ECHO, CH_BS, 1'b0, 1'b0);
        push_beat(KIND_ECHO, CH_SP, 1'b0, 1'b0);
        push_beat(KIND_ECHO, CH_BS, 1'b1, 1'b0);
        return 3;
      end
      if (held < DEPTH - 2) begin
        line_mem[held] = rx;
        held++;
        push_beat(KIND_ECHO, rx, 1'b1, 1'b0);
        return 1;
      end
      return 0;
    endfunction

    task report_mismatch(input string what);
      errors++;
      if (errors <= 40) $display("[%0t] beat %0d: %s", $realtime, beat_no, what);
    endtask

    task check_beat(input logic [1:0] kind, input logic [7:0] data,
                    input logic last, input logic le);
      line_beat_t want;
      beat_no++;
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat, kind %0d data %02h", kind, data));
        return;
      end
      want = expected_beats.pop_front();
      if (kind !== want.kind)
        report_mismatch($sformatf("kind %0d, wanted %0d", kind, want.kind));
      if (data !== want.data_byte)
        report_mismatch($sformatf("data_byte %02h, wanted %02h", data, want.data_byte));
      if (last !== want.run_last)
        report_mismatch($sformatf("run_last %b, wanted %b", last, want.run_last));
      if (le !== want.line_end)
        report_mismatch($sformatf("line_end %b, wanted %b", le, want.line_end));
    endtask
  endclass

  // Clock, reset and the signals the testbench drives. Every one of them has a
  // known value from time zero.
  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       src_valid  = 1'b0;
  logic       src_req    = REQ_RX;
  logic [7:0] src_byte   = 8'h00;
  logic       sink_ready = 1'b0;

  // When clear, neither side inserts gaps or stalls.
  bit idle_on      = 1'b1;
  int useful_items = 0;
  int stall_left   = 0;

  line_echo_scoreboard #(LINE_DEPTH) sb;

  cleb_in_if  in_ch();
  cleb_out_if out_ch();

  assign in_ch.valid    = src_valid;
  assign in_ch.req_type = src_req;
  assign in_ch.rx_byte  = src_byte;
  assign out_ch.ready   = sink_ready;

  console_line_edit_buffer #(.LINE_DEPTH(LINE_DEPTH)) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // A random byte that the editor simply stores and echoes.
  function automatic logic [7:0] rand_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_CR || b == CH_LF || b == CH_BS || b == CH_DEL);
    return b;
  endfunction

  // Offers one request and holds it until the block takes the beat. Valid is
  // only lowered when a gap is about to follow, so that back-to-back requests
  // never see valid dropped and raised within the same time step.
  task automatic send_item(input logic req, input logic [7:0] rx);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_req   <= req;
    src_byte  <= rx;
    do @(posedge clk); while (!in_ch.ready);
    if (sb.absorb_item(req, rx) > 0) useful_items++;
  endtask

  // Stops offering requests until every predicted beat has left the block.
  task automatic drain_output();
    src_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Types a line of the given length with the odd erase and the odd read
  // arriving too early, which must be answered with "no line ready".
  task automatic edit_line(input int len);
    int pick;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12)
        send_item(REQ_RX, ($urandom_range(0, 1) != 0) ? CH_BS : CH_DEL);
      else if (pick < 16)
        send_item(REQ_READ, 8'($urandom_range(0, 255)));
      else
        send_item(REQ_RX, rand_plain());
    end
  endtask

  // Reads the completed line out to its newline. With noise, the odd received
  // byte is slipped in and should be refused without disturbing the delivery.
  task automatic deliver_line(input bit noisy);
    while (sb.delivering) begin
      if (noisy && $urandom_range(0, 11) == 0)
        send_item(REQ_RX, 8'($urandom_range(0, 255)));
      else
        send_item(REQ_READ, 8'($urandom_range(0, 255)));
    end
  endtask

  // Output side: each beat taken is checked against the oldest prediction,
  // then ready for the next cycle is chosen. Stalls come in bursts.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_beat(out_ch.kind, out_ch.data_byte, out_ch.run_last, out_ch.line_end);
    if (stall_left > 0) begin
      stall_left--;
      sink_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Watchdog: a long stretch with no beat on either channel means the block
  // has hung, so the run is abandoned as a failure.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Main sequence: directed checks, then random editing sessions.
  initial begin
    int pick;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A read before any line is complete must report that no
    // line is ready, and erasing an empty line must do nothing at all.
    send_item(REQ_READ, 8'hFF);
    send_item(REQ_RX, CH_BS);
    send_item(REQ_RX, CH_DEL);
    // Extremes of the byte range and a plain letter, then both erase codes removing the last two again.
    send_item(REQ_RX, 8'h00);
    send_item(REQ_RX, 8'hFF);
    send_item(REQ_RX, 8'h41);
    send_item(REQ_RX, CH_BS);
    send_item(REQ_RX, CH_DEL);
    send_item(REQ_RX, 8'h7E);
    send_item(REQ_RX, 8'h80);
    // CR completes the line; a byte received during delivery is refused.
    send_item(REQ_RX, CH_CR);
    send_item(REQ_RX, 8'h55);
    repeat (4) send_item(REQ_READ, 8'h00);
    // The line has gone, so the next read finds nothing ready.
    send_item(REQ_READ, 8'h00);
    // Lines holding nothing but the newline, closed by LF and by CR.
    send_item(REQ_RX, CH_LF);
    send_item(REQ_READ, 8'h00);
    send_item(REQ_RX, CH_CR);
    send_item(REQ_READ, 8'h00);

    // Hold the input back until the output has caught up completely.
    drain_output();

    // Random part. Most sessions are well-formed lines with random content;
    // the rest is raw noise. The last stretch runs with no idling at all.
    while (useful_items < RANDOM_ITEMS) begin
      if (useful_items < RANDOM_ITEMS - 40)
        idle_on = ($urandom_range(0, 3) != 0);
      else
        idle_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        deliver_line(1'b0);
        if ($urandom_range(0, 3) == 0) edit_line($urandom_range(0, 40));
        else edit_line($urandom_range(0, 10));
        send_item(REQ_RX, ($urandom_range(0, 1) != 0) ? CH_CR : CH_LF);
        deliver_line(1'b1);
        if ($urandom_range(0, 2) == 0) send_item(REQ_READ, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end

    // Wind down: wait for every predicted beat, then wait out the quiet tail to
    // catch anything the block might still emit on its own.
    idle_on = 1'b0;
    drain_output();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
